@@ sv/escape_time_fractal_pixel_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the escape-time fractal pixel core
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_CORE_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_CORE_ASSERT_SVH

// same-cycle implication
`define EFP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/efp_pkg.sv @@
// ----------------------------------------------------------------------------
// efp_pkg
// Shared constants, controller states and command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package efp_pkg;

    localparam int FRAC_BITS = 40;
    localparam int PAL_SIZE  = 16384;
    localparam int ESC_BIT   = 2 * FRAC_BITS + 16;
    localparam logic [15:0] GAMMA_Q16 = 16'd24248;

    localparam logic [3:0] CFG_START_RE = 4'd0;
    localparam logic [3:0] CFG_START_IM = 4'd1;
    localparam logic [3:0] CFG_STEP_RE  = 4'd2;
    localparam logic [3:0] CFG_STEP_IM  = 4'd3;
    localparam logic [3:0] CFG_MAX_ITER = 4'd4;
    localparam logic [3:0] CFG_JULIA_EN = 4'd5;
    localparam logic [3:0] CFG_JULIA_RE = 4'd6;
    localparam logic [3:0] CFG_JULIA_IM = 4'd7;

    typedef enum logic [4:0] {
        S_IDLE, S_PIX, S_SEED, S_MUL, S_CORR, S_CHECK,
        S_L1_GO, S_L1_WAIT, S_L2_GO, S_L2_WAIT, S_MU,
        S_DIV_GO, S_DIV_WAIT, S_L3_GO, S_L3_WAIT, S_EXP,
        S_SQ_GO, S_SQ_WAIT, S_SCALE, S_DONE
    } t_state;

    typedef enum logic [1:0] {LS_MAG, LS_L1, LS_T32} t_log_src;

    typedef enum logic [1:0] {LG_IDLE, LG_NORM, LG_SQR} t_log_phase;

    typedef struct packed {
        logic       load;
        logic       pix;
        logic       seed;
        logic       mul;
        logic [1:0] pp_sel;
        logic       corr;
        logic       check;
        logic       log_go;
        logic       log_take;
        t_log_src   log_src;
        logic       mu;
        logic       div_go;
        logic       div_take;
        logic       expo;
        logic       sq_go;
        logic       sq_take;
        logic [3:0] pw_idx;
        logic       scale;
    } t_cmd;

    typedef struct packed {
        logic escaped;
        logic at_limit;
        logic log_done;
        logic div_done;
        logic sq_done;
        logic mu_clamp;
    } t_status;

endpackage

`default_nettype wire

@@ sv/efp_log2.sv @@
// ----------------------------------------------------------------------------
// efp_log2
// Iterative log2 in Q16: leading-one search, then 16 mantissa squarings.
// ----------------------------------------------------------------------------
`default_nettype none

module efp_log2 (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_go,
    input  wire logic [127:0] i_x,
    output logic              o_done,
    output logic [22:0]       o_res
);
    import efp_pkg::*;

    t_log_phase   r_phase, n_phase;
    logic [127:0] r_x, n_x;
    logic [6:0]   r_p, n_p;
    logic [31:0]  r_m, n_m;
    logic [15:0]  r_fr, n_fr;
    logic [3:0]   r_cnt, n_cnt;
    logic         r_done, n_done;
    logic [63:0]  sq;
    logic [32:0]  s;

    assign sq = {32'b0, r_m} * {32'b0, r_m};
    assign s  = sq[63:31];

    always_comb begin
        n_phase = r_phase;
        n_x     = r_x;
        n_p     = r_p;
        n_m     = r_m;
        n_fr    = r_fr;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        unique case (r_phase)
            LG_IDLE: begin
                if (i_go) begin
                    if (i_x == '0) begin
                        n_p    = '0;
                        n_fr   = '0;
                        n_done = 1'b1;
                    end else begin
                        n_x     = i_x;
                        n_p     = 7'd127;
                        n_phase = LG_NORM;
                    end
                end
            end
            LG_NORM: begin
                priority if (r_x[127:112] == '0) begin
                    n_x = {r_x[111:0], 16'b0};
                    n_p = r_p - 7'd16;
                end else if (!r_x[127]) begin
                    n_x = {r_x[126:0], 1'b0};
                    n_p = r_p - 7'd1;
                end else begin
                    n_m     = r_x[127:96];
                    n_fr    = '0;
                    n_cnt   = '0;
                    n_phase = LG_SQR;
                end
            end
            LG_SQR: begin
                n_fr  = {r_fr[14:0], s[32]};
                n_m   = s[32] ? s[32:1] : s[31:0];
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_phase = LG_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: n_phase = LG_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= LG_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
        r_x   <= n_x;
        r_p   <= n_p;
        r_m   <= n_m;
        r_fr  <= n_fr;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_res  = {r_p, r_fr};

endmodule

`default_nettype wire

@@ sv/efp_div.sv @@
// ----------------------------------------------------------------------------
// efp_div
// Restoring divider, 48-bit dividend by 16-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module efp_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire logic [47:0] i_num,
    input  wire logic [15:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_quot
);
    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [47:0] r_q;
    logic [15:0] r_rem, r_den;
    logic [16:0] t, d;
    logic        ge;

    assign t  = {r_rem, r_q[47]};
    assign ge = t >= {1'b0, r_den};
    assign d  = t - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 6'd47) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_go) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[46:0], ge};
            r_rem <= ge ? d[15:0] : t[15:0];
            r_cnt <= r_cnt + 6'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q[31:0];

endmodule

`default_nettype wire

@@ sv/efp_sqrt.sv @@
// ----------------------------------------------------------------------------
// efp_sqrt
// Digit-by-digit floor square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module efp_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire logic [63:0] i_op,
    output logic             o_done,
    output logic [31:0]      o_root
);
    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_op;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [35:0] t, trial, d;
    logic        ge;

    assign t     = {r_rem, r_op[63:62]};
    assign trial = {2'b0, r_root, 2'b01};
    assign ge    = t >= trial;
    assign d     = t - trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_go) begin
            r_op   <= i_op;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_op   <= {r_op[61:0], 2'b00};
            r_rem  <= ge ? d[33:0] : t[33:0];
            r_root <= {r_root[30:0], ge};
            r_cnt  <= r_cnt + 5'd1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

@@ sv/efp_datapath.sv @@
// ----------------------------------------------------------------------------
// efp_datapath
// Config registers, z iteration on three 32x32 multipliers, smooth-color math.
// ----------------------------------------------------------------------------
`default_nettype none

module efp_datapath (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_valid,
    input  wire logic [3:0]     i_cfg_index,
    input  wire logic [47:0]    i_cfg_data,
    input  wire logic [11:0]    i_column,
    input  wire logic [11:0]    i_row,
    input  wire efp_pkg::t_cmd  i_cmd,
    output efp_pkg::t_status    o_status,
    output logic [14:0]         o_color_index,
    output logic [15:0]         o_iteration_count,
    output logic                o_interior
);
    import efp_pkg::*;

    // configuration
    logic [47:0] r_start_re, r_start_im, r_julia_re, r_julia_im;
    logic [46:0] r_step_re, r_step_im;
    logic [15:0] r_max_iter;
    logic        r_julia_en;

    // per-pixel state
    logic [11:0]  r_col, r_row;
    logic [58:0]  r_pr, r_pi;
    logic [63:0]  r_zr, r_zi, r_cr, r_ci;
    logic [15:0]  r_lim, r_iter;
    logic [127:0] r_rr, r_ii, r_ri, r_mag;
    logic [22:0]  r_l1, r_l2, r_l3;
    logic [31:0]  r_mu, r_t32;
    logic [5:0]   r_k;
    logic [15:0]  r_f16;
    logic [32:0]  r_r;
    logic [14:0]  r_idx;
    logic         r_inside;

    logic [31:0]  zr_hi_sel, zr_lo_sel, zi_hi_sel, zi_lo_sel;
    logic [63:0]  pp_rr, pp_ii, pp_ri;
    logic [6:0]   pp_sh;
    logic [127:0] acc_rr, acc_ii, acc_ri;
    logic [63:0]  rr_hi, ii_hi, ri_hi;
    logic [127:0] sum, diff;
    logic [63:0]  zr_next, zi_next, zr_seed, zi_seed;
    logic [15:0]  lim_seed;
    logic         escaped, at_limit;
    logic [127:0] log_x;
    logic         log_done, div_done, sq_done;
    logic [22:0]  log_res;
    logic [31:0]  div_quot, sq_root;
    logic [16:0]  iter_p1;
    logic [34:0]  mu_full;
    logic [31:0]  den;
    logic         mu_low, mu_high;
    logic [22:0]  nl;
    logic [36:0]  ne;
    logic [31:0]  neg_fl;
    logic [32:0]  r_dbl;
    logic [63:0]  sq_op;
    logic [45:0]  scaled;
    logic [5:0]   shamt;
    logic [63:0]  shifted;

    // partial products: pp_sel[1] picks the high half of a, pp_sel[0] of b
    assign zr_hi_sel = i_cmd.pp_sel[1] ? r_zr[63:32] : r_zr[31:0];
    assign zr_lo_sel = i_cmd.pp_sel[0] ? r_zr[63:32] : r_zr[31:0];
    assign zi_hi_sel = i_cmd.pp_sel[1] ? r_zi[63:32] : r_zi[31:0];
    assign zi_lo_sel = i_cmd.pp_sel[0] ? r_zi[63:32] : r_zi[31:0];
    assign pp_rr = {32'b0, zr_hi_sel} * {32'b0, zr_lo_sel};
    assign pp_ii = {32'b0, zi_hi_sel} * {32'b0, zi_lo_sel};
    assign pp_ri = {32'b0, zr_hi_sel} * {32'b0, zi_lo_sel};
    assign pp_sh = {i_cmd.pp_sel[1] & i_cmd.pp_sel[0],
                    i_cmd.pp_sel[1] ^ i_cmd.pp_sel[0], 5'b0};

    always_comb begin
        acc_rr = {64'b0, pp_rr} << pp_sh;
        acc_ii = {64'b0, pp_ii} << pp_sh;
        acc_ri = {64'b0, pp_ri} << pp_sh;
        if (i_cmd.pp_sel != 2'b00) begin
            acc_rr = acc_rr + r_rr;
            acc_ii = acc_ii + r_ii;
            acc_ri = acc_ri + r_ri;
        end
    end

    // signed correction of the unsigned 64x64 products
    assign rr_hi = r_rr[127:64] - (r_zr[63] ? {r_zr[62:0], 1'b0} : 64'b0);
    assign ii_hi = r_ii[127:64] - (r_zi[63] ? {r_zi[62:0], 1'b0} : 64'b0);
    assign ri_hi = r_ri[127:64] - (r_zr[63] ? r_zi : 64'b0) - (r_zi[63] ? r_zr : 64'b0);

    assign sum      = r_rr + r_ii;
    assign diff     = r_rr - r_ii;
    assign zr_next  = diff[FRAC_BITS+63:FRAC_BITS] + r_cr;
    assign zi_next  = r_ri[FRAC_BITS+62:FRAC_BITS-1] + r_ci;
    assign escaped  = |sum[127:ESC_BIT];
    assign at_limit = {1'b0, r_iter} >= ({1'b0, r_lim} - 17'd1);

    assign zr_seed  = {{16{r_start_re[47]}}, r_start_re} + {5'b0, r_pr};
    assign zi_seed  = {{16{r_start_im[47]}}, r_start_im} + {5'b0, r_pi};
    assign lim_seed = (r_max_iter < 16'd2) ? 16'd2 : r_max_iter;

    always_comb begin
        unique case (i_cmd.log_src)
            LS_MAG:  log_x = r_mag;
            LS_L1:   log_x = {105'b0, r_l1};
            LS_T32:  log_x = {96'b0, r_t32};
            default: log_x = r_mag;
        endcase
    end

    assign iter_p1 = {1'b0, r_iter} + 17'd1;
    assign mu_full = {2'b0, iter_p1, 16'b0} - {12'b0, r_l2};
    assign den     = {r_lim - 16'd1, 16'b0};
    assign mu_low  = mu_full[34] || (mu_full == '0);
    assign mu_high = !mu_full[34] && (mu_full[33:0] >= {2'b0, den});

    assign nl     = 23'(32 * 65536) - r_l3;
    assign ne     = {15'b0, nl[21:0]} * {21'b0, GAMMA_Q16};
    assign neg_fl = 32'd0 - ne[31:0];

    assign r_dbl  = r_f16[i_cmd.pw_idx] ? {r_r[31:0], 1'b0} : r_r;
    assign sq_op  = {1'b0, r_dbl, 30'b0};

    assign scaled  = {14'b0, r_r[31:0]} * 46'(PAL_SIZE - 1);
    assign shamt   = 6'd30 + r_k;
    assign shifted = {18'b0, scaled} >> shamt;

    efp_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.log_go),
        .i_x     (log_x),
        .o_done  (log_done),
        .o_res   (log_res)
    );

    efp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   ({r_mu, 16'b0}),
        .i_den   (r_lim - 16'd1),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    efp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.sq_go),
        .i_op    (sq_op),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_re <= 48'hFD8C_CCCC_CCCD;
            r_start_im <= 48'hFEC4_4444_4445;
            r_step_re  <= 47'd3390161519;
            r_step_im  <= 47'd3390161519;
            r_max_iter <= 16'd100;
            r_julia_en <= 1'b0;
            r_julia_re <= 48'hFF99_9999_999A;
            r_julia_im <= 48'h0099_9999_999A;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_RE: r_start_re <= i_cfg_data;
                CFG_START_IM: r_start_im <= i_cfg_data;
                CFG_STEP_RE:  r_step_re  <= i_cfg_data[46:0];
                CFG_STEP_IM:  r_step_im  <= i_cfg_data[46:0];
                CFG_MAX_ITER: r_max_iter <= i_cfg_data[15:0];
                CFG_JULIA_EN: r_julia_en <= i_cfg_data[0];
                CFG_JULIA_RE: r_julia_re <= i_cfg_data;
                CFG_JULIA_IM: r_julia_im <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col <= i_column;
            r_row <= i_row;
        end
        if (i_cmd.pix) begin
            r_pr <= {47'b0, r_col} * {12'b0, r_step_re};
            r_pi <= {47'b0, r_row} * {12'b0, r_step_im};
        end
        if (i_cmd.seed) begin
            r_zr     <= zr_seed;
            r_zi     <= zi_seed;
            r_cr     <= r_julia_en ? {{16{r_julia_re[47]}}, r_julia_re} : zr_seed;
            r_ci     <= r_julia_en ? {{16{r_julia_im[47]}}, r_julia_im} : zi_seed;
            r_lim    <= lim_seed;
            r_iter   <= '0;
            r_inside <= 1'b0;
        end
        if (i_cmd.mul) begin
            r_rr <= acc_rr;
            r_ii <= acc_ii;
            r_ri <= acc_ri;
        end
        if (i_cmd.corr) begin
            r_rr[127:64] <= rr_hi;
            r_ii[127:64] <= ii_hi;
            r_ri[127:64] <= ri_hi;
        end
        if (i_cmd.check) begin
            priority if (escaped) begin
                r_mag <= sum;
            end else if (at_limit) begin
                r_iter   <= r_lim;
                r_inside <= 1'b1;
                r_idx    <= 15'(PAL_SIZE);
            end else begin
                r_iter <= r_iter + 16'd1;
                r_zr   <= zr_next;
                r_zi   <= zi_next;
            end
        end
        if (i_cmd.log_take && log_done) begin
            unique case (i_cmd.log_src)
                LS_MAG:  r_l1 <= log_res - 23'((2 * FRAC_BITS) * 65536);
                LS_L1:   r_l2 <= log_res - 23'(17 * 65536);
                LS_T32:  r_l3 <= log_res;
                default: r_l3 <= log_res;
            endcase
        end
        if (i_cmd.mu) begin
            r_mu  <= mu_full[31:0];
            r_idx <= mu_low ? 15'd0 : 15'(PAL_SIZE - 1);
        end
        if (i_cmd.div_take && div_done) begin
            r_t32 <= div_quot;
        end
        if (i_cmd.expo) begin
            r_k   <= {1'b0, ne[36:32]} + {5'b0, (ne[31:0] != 32'd0)};
            r_f16 <= neg_fl[31:16];
            r_r   <= 33'h0_4000_0000;
        end
        if (i_cmd.sq_take && sq_done) begin
            r_r <= {1'b0, sq_root};
        end
        if (i_cmd.scale) begin
            r_idx <= (r_k > 6'd33) ? 15'd0 : shifted[14:0];
        end
    end

    assign o_status.escaped  = escaped;
    assign o_status.at_limit = at_limit;
    assign o_status.log_done = log_done;
    assign o_status.div_done = div_done;
    assign o_status.sq_done  = sq_done;
    assign o_status.mu_clamp = mu_low || mu_high;

    assign o_color_index     = r_idx;
    assign o_iteration_count = r_iter;
    assign o_interior        = r_inside;

endmodule

`default_nettype wire

@@ sv/efp_ctrl.sv @@
// ----------------------------------------------------------------------------
// efp_ctrl
// Sequencer: pixel setup, iteration loop, smooth-color steps, result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module efp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire efp_pkg::t_status  i_status,
    output efp_pkg::t_cmd          o_cmd,
    output logic                   o_busy,
    output logic                   o_valid
);
    import efp_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_pp;
    logic [3:0] r_pw;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_start) n_state = S_PIX;
            S_PIX:      n_state = S_SEED;
            S_SEED:     n_state = S_MUL;
            S_MUL:      if (r_pp == 2'd3) n_state = S_CORR;
            S_CORR:     n_state = S_CHECK;
            S_CHECK: begin
                priority if (i_status.escaped) n_state = S_L1_GO;
                else if (i_status.at_limit)    n_state = S_DONE;
                else                           n_state = S_MUL;
            end
            S_L1_GO:    n_state = S_L1_WAIT;
            S_L1_WAIT:  if (i_status.log_done) n_state = S_L2_GO;
            S_L2_GO:    n_state = S_L2_WAIT;
            S_L2_WAIT:  if (i_status.log_done) n_state = S_MU;
            S_MU:       n_state = i_status.mu_clamp ? S_DONE : S_DIV_GO;
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: if (i_status.div_done) n_state = S_L3_GO;
            S_L3_GO:    n_state = S_L3_WAIT;
            S_L3_WAIT:  if (i_status.log_done) n_state = S_EXP;
            S_EXP:      n_state = S_SQ_GO;
            S_SQ_GO:    n_state = S_SQ_WAIT;
            S_SQ_WAIT: begin
                if (i_status.sq_done) n_state = (r_pw == 4'd15) ? S_SCALE : S_SQ_GO;
            end
            S_SCALE:    n_state = S_DONE;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.log_src = LS_MAG;
        o_cmd.pp_sel  = r_pp;
        o_cmd.pw_idx  = r_pw;
        unique case (r_state)
            S_IDLE:     o_cmd.load = i_start;
            S_PIX:      o_cmd.pix = 1'b1;
            S_SEED:     o_cmd.seed = 1'b1;
            S_MUL:      o_cmd.mul = 1'b1;
            S_CORR:     o_cmd.corr = 1'b1;
            S_CHECK:    o_cmd.check = 1'b1;
            S_L1_GO:    o_cmd.log_go = 1'b1;
            S_L1_WAIT:  o_cmd.log_take = 1'b1;
            S_L2_GO: begin
                o_cmd.log_go  = 1'b1;
                o_cmd.log_src = LS_L1;
            end
            S_L2_WAIT: begin
                o_cmd.log_take = 1'b1;
                o_cmd.log_src  = LS_L1;
            end
            S_MU:       o_cmd.mu = 1'b1;
            S_DIV_GO:   o_cmd.div_go = 1'b1;
            S_DIV_WAIT: o_cmd.div_take = 1'b1;
            S_L3_GO: begin
                o_cmd.log_go  = 1'b1;
                o_cmd.log_src = LS_T32;
            end
            S_L3_WAIT: begin
                o_cmd.log_take = 1'b1;
                o_cmd.log_src  = LS_T32;
            end
            S_EXP:      o_cmd.expo = 1'b1;
            S_SQ_GO:    o_cmd.sq_go = 1'b1;
            S_SQ_WAIT:  o_cmd.sq_take = 1'b1;
            S_SCALE:    o_cmd.scale = 1'b1;
            S_DONE:     ;
            default:    ;
        endcase
        o_busy  = (r_state != S_IDLE);
        o_valid = (r_state == S_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pp    <= '0;
            r_pw    <= '0;
        end else begin
            r_state <= n_state;
            r_pp    <= (r_state == S_MUL) ? r_pp + 2'd1 : 2'd0;
            if (r_state == S_EXP) begin
                r_pw <= '0;
            end else if (r_state == S_SQ_WAIT && i_status.sq_done) begin
                r_pw <= r_pw + 4'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/escape_time_fractal_pixel_core.sv @@
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_core
// Mandelbrot/Julia escape-time pixel engine with smooth color index.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel command: drive i_column/i_row with start high while busy is low;
//   busy rises the next cycle and stays up until the result is out.
//   Result: o_valid is high for exactly one cycle with o_color_index,
//   o_iteration_count and o_interior; there is no backpressure, the
//   receiver must take it in that cycle. busy drops the cycle after.
//   Config: i_cfg_valid/o_cfg_ready write channel (ready is always high),
//   i_cfg_index selects the register; write only while busy is low.
//   Sequence:
//   Setup is the pixel-offset and seed steps. Each z iteration runs four
//   partial products on three 32x32 multipliers, a sign correction, then
//   escape test/update.
//   An escaped pixel then runs smooth coloring: two log2 passes, the
//   48-step divider, a third log2 pass and sixteen 32-step square roots;
//   a clamped mu ends the pixel after the second log2 pass.
//   Reset returns the sequencer to idle and loads the default view.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_time_fractal_pixel_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [11:0] i_column,
    input  wire logic [11:0] i_row,
    output logic             o_valid,
    output logic [14:0]      o_color_index,
    output logic [15:0]      o_iteration_count,
    output logic             o_interior,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data
);
    import efp_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    efp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    efp_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_column          (i_column),
        .i_row             (i_row),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_color_index     (o_color_index),
        .o_iteration_count (o_iteration_count),
        .o_interior        (o_interior)
    );

endmodule

`default_nettype wire

@@ sv/efp_checker.sv @@
// ----------------------------------------------------------------------------
// efp_checker
// Port-level checks on the pixel core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "escape_time_fractal_pixel_core_assert.svh"

module efp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [14:0] o_color_index,
    input wire logic        o_interior
);
    `EFP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "transfer accepted but busy low")
    `EFP_ASSERT_SAME(a_valid_busy, o_valid, busy, "result strobe while idle")
    `EFP_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid && !busy, "result not single cycle")
    `EFP_ASSERT_SAME(a_interior_idx, o_valid && o_interior, o_color_index == 15'd16384, "interior index")
    `EFP_ASSERT_SAME(a_escape_idx, o_valid && !o_interior, o_color_index < 15'd16384, "escape index range")
endmodule

bind escape_time_fractal_pixel_core efp_checker u_efp_checker (.*);

`default_nettype wire
